### design/hhtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhtd_pkg
// Shared types and constants of the heap-tree Huffman decoder: operation and
// result codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package hhtd_pkg;

    // Default sizes of the tree store and the symbol map.
    localparam int TREE_NODES_DEF   = 1024;
    localparam int SYMBOL_SLOTS_DEF = 64;

    // Field widths fixed by the interface.
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 10;
    localparam int WEIGHT_W = 16;
    localparam int LEAF_W   = 10;
    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 2;
    localparam int EFF_W    = 16;
    localparam int SCNT_W   = 7;
    localparam int CNT_W    = 32;

    // Efficiency: bits * 100 / (symbols * 8).
    localparam int EFF_SCALE  = 100;
    localparam int CHAR_SHIFT = 3;
    localparam int NUM_W      = CNT_W + 7;
    localparam int DEN_W      = CNT_W + CHAR_SHIFT;
    localparam int DIVC_W     = $clog2(NUM_W + 1);

    // Packed beat widths.
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_TREE = 2'd0,
        OP_MAP  = 2'd1,
        OP_BIT  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SYMBOL   = 2'd0,
        KIND_REPORT   = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK1,
        S_CHK2,
        S_SCAN,
        S_SYM_OUT,
        S_OVF_OUT,
        S_MUL,
        S_DIV,
        S_RPT_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  clr_en;
        logic  take_tree;
        logic  take_map;
        logic  take_bit;
        logic  step;
        logic  ovf_done;
        logic  leaf_read;
        logic  scan_start;
        logic  scan_step;
        logic  scan_take;
        logic  sym_done;
        logic  mul;
        logic  div_step;
        logic  rpt_done;
        logic  out_load;
        kind_t out_kind;
        logic  out_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic has_left;
        logic overflow;
        logic scan_empty;
        logic scan_match;
        logic scan_last;
        logic div_done;
        logic eos;
        logic out_free;
    } status_t;

endpackage

### design/hhtd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhtd_ctrl
// Controller of the decoder: sequences the tree clearing pass, the input
// beats, the tree walk, the symbol map scan and the efficiency division.
// ----------------------------------------------------------------------------
module hhtd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  hhtd_pkg::op_t    in_op,
    output logic             in_ready,
    input  hhtd_pkg::status_t status,
    output hhtd_pkg::cmd_t   cmd
);
    import hhtd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign in_ready = (state_reg == S_IDLE);
    assign take     = in_valid && in_ready;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_kind = KIND_SYMBOL;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    unique case (in_op)
                        OP_TREE: cmd.take_tree = 1'b1;
                        OP_MAP:  cmd.take_map  = 1'b1;
                        OP_BIT:
                        begin
                            cmd.take_bit = 1'b1;
                            state_next   = S_CHK1;
                        end
                        OP_NONE: state_next = S_IDLE;
                    endcase
                end
            end
            S_CHK1:
            begin
                // The read of the current node's left child has landed.
                if (status.has_left)
                begin
                    if (status.overflow)
                    begin
                        state_next = S_OVF_OUT;
                    end
                    else
                    begin
                        cmd.step   = 1'b1;
                        state_next = S_CHK2;
                    end
                end
                else
                begin
                    cmd.leaf_read  = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_CHK2:
            begin
                // Check whether the node just stepped to is a leaf.
                if (status.has_left)
                begin
                    state_next = status.eos ? S_MUL : S_IDLE;
                end
                else
                begin
                    cmd.leaf_read  = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Map slots are scanned from the top down so the first hit is the last match.
                if (status.scan_empty)
                begin
                    state_next = S_SYM_OUT;
                end
                else if (status.scan_match)
                begin
                    cmd.scan_take = 1'b1;
                    state_next    = S_SYM_OUT;
                end
                else if (status.scan_last)
                begin
                    state_next = S_SYM_OUT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SYM_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_SYMBOL;
                    cmd.out_last = !status.eos;
                    cmd.sym_done = 1'b1;
                    state_next   = status.eos ? S_MUL : S_IDLE;
                end
            end
            S_OVF_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_OVERFLOW;
                    cmd.out_last = !status.eos;
                    cmd.ovf_done = 1'b1;
                    state_next   = status.eos ? S_MUL : S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_RPT_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_RPT_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_REPORT;
                    cmd.out_last = 1'b1;
                    cmd.rpt_done = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### design/hhtd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhtd_datapath
// Datapath of the decoder: tree store and symbol map memories, walk position,
// bit and symbol counters, the bit-serial divider and the output register.
// ----------------------------------------------------------------------------
module hhtd_datapath
#(
    parameter int TREE_NODES   = hhtd_pkg::TREE_NODES_DEF,
    parameter int SYMBOL_SLOTS = hhtd_pkg::SYMBOL_SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  hhtd_pkg::cmd_t                cmd,
    output hhtd_pkg::status_t             status,
    input  logic [hhtd_pkg::ADDR_W-1:0]   in_address,
    input  logic [hhtd_pkg::WEIGHT_W-1:0] in_node_weight,
    input  logic [hhtd_pkg::LEAF_W-1:0]   in_leaf_position,
    input  logic [hhtd_pkg::CHAR_W-1:0]   in_symbol_char,
    input  logic                          in_code_bit,
    input  logic                          in_end_of_stream,
    input  logic                          cfg_wr_en,
    input  logic [hhtd_pkg::SCNT_W-1:0]   cfg_wr_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output hhtd_pkg::kind_t               out_kind,
    output logic [hhtd_pkg::WEIGHT_W-1:0] out_weight,
    output logic [hhtd_pkg::CHAR_W-1:0]   out_symbol,
    output logic                          out_symbol_found,
    output logic [hhtd_pkg::EFF_W-1:0]    out_efficiency,
    output logic                          out_incomplete,
    output logic                          out_last
);
    import hhtd_pkg::*;

    localparam int TAW  = $clog2(TREE_NODES);
    localparam int SAW  = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;
    localparam int SCW  = $clog2(SYMBOL_SLOTS + 1);

    // Memories.
    logic [WEIGHT_W-1:0] tree_mem [TREE_NODES];
    logic [LEAF_W-1:0]   map_leaf_mem [SYMBOL_SLOTS];
    logic [CHAR_W-1:0]   map_char_mem [SYMBOL_SLOTS];

    // Control and working registers.
    logic [SCNT_W-1:0]   symbol_count_reg;
    logic [TAW-1:0]      clr_idx_reg;
    logic [TAW-1:0]      walk_reg;
    logic [TAW-1:0]      walk_next;
    logic                bit_reg;
    logic                eos_reg;
    logic [CNT_W-1:0]    bits_reg;
    logic [CNT_W-1:0]    syms_reg;
    logic [WEIGHT_W-1:0] tree_rd_reg;
    logic [LEAF_W-1:0]   map_leaf_rd_reg;
    logic [CHAR_W-1:0]   map_char_rd_reg;
    logic [SAW-1:0]      scan_idx_reg;
    logic [SAW-1:0]      scan_idx_next;
    logic                found_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic                inc_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [DIVC_W-1:0]   div_cnt_reg;

    // Output register.
    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic [WEIGHT_W-1:0] out_weight_reg;
    logic [CHAR_W-1:0]   out_symbol_reg;
    logic                out_found_reg;
    logic [EFF_W-1:0]    out_eff_reg;
    logic                out_inc_reg;
    logic                out_last_reg;

    // Combinational signals.
    logic [TAW:0]        left_pos;
    logic [TAW:0]        child_pos;
    logic                left_ok;
    logic                tree_we;
    logic [TAW-1:0]      tree_waddr;
    logic [WEIGHT_W-1:0] tree_wdata;
    logic                tree_re;
    logic [TAW-1:0]      tree_raddr;
    logic                map_we;
    logic [SCW-1:0]      slot_cnt;
    logic [DEN_W-1:0]    den;
    logic [DEN_W:0]      trial;
    logic [DEN_W:0]      diff;
    logic                fits;
    logic [EFF_W-1:0]    eff;

    // Walk geometry: left child, taken child and the left child's range check.
    assign left_pos  = {walk_reg, 1'b0};
    assign child_pos = {walk_reg, bit_reg};
    assign left_ok   = 32'(left_pos) < TREE_NODES;

    // Valid map slots, limited to the map size.
    assign slot_cnt = (32'(symbol_count_reg) > SYMBOL_SLOTS) ? SCW'(SYMBOL_SLOTS)
                                                              : SCW'(symbol_count_reg);

    // Tree store ports.
    always_comb
    begin
        tree_we    = cmd.clr_en
                  || (cmd.take_tree && (32'(in_address) < TREE_NODES));
        tree_waddr = cmd.clr_en ? clr_idx_reg : TAW'(in_address);
        tree_wdata = cmd.clr_en ? '0 : in_node_weight;
        tree_re    = cmd.take_bit || cmd.step || cmd.leaf_read;
        if (cmd.step)
        begin
            tree_raddr = TAW'({child_pos, 1'b0});
        end
        else if (cmd.leaf_read)
        begin
            tree_raddr = walk_reg;
        end
        else
        begin
            tree_raddr = TAW'(left_pos);
        end
    end

    always_ff @(posedge clk)
    begin
        if (tree_we)
        begin
            tree_mem[tree_waddr] <= tree_wdata;
        end
        if (tree_re)
        begin
            tree_rd_reg <= tree_mem[tree_raddr];
        end
    end

    // Symbol map: the read address runs one step ahead so the read data
    // always belongs to the current scan index.
    assign map_we = cmd.take_map && (32'(in_address) < SYMBOL_SLOTS);

    always_comb
    begin
        if (cmd.scan_start)
        begin
            scan_idx_next = SAW'(slot_cnt - 1'b1);
        end
        else if (cmd.scan_step)
        begin
            scan_idx_next = scan_idx_reg - 1'b1;
        end
        else
        begin
            scan_idx_next = scan_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_leaf_mem[SAW'(in_address)] <= in_leaf_position;
            map_char_mem[SAW'(in_address)] <= in_symbol_char;
        end
        map_leaf_rd_reg <= map_leaf_mem[scan_idx_next];
        map_char_rd_reg <= map_char_mem[scan_idx_next];
    end

    // Walk position update.
    always_comb
    begin
        if (cmd.ovf_done || cmd.sym_done || cmd.rpt_done)
        begin
            walk_next = TAW'(1);
        end
        else if (cmd.step)
        begin
            walk_next = TAW'(child_pos);
        end
        else
        begin
            walk_next = walk_reg;
        end
    end

    // Control state: configuration, clearing pass, walk and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= '0;
            clr_idx_reg      <= '0;
            walk_reg         <= TAW'(1);
            bits_reg         <= '0;
            syms_reg         <= '0;
            scan_idx_reg     <= '0;
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                symbol_count_reg <= cfg_wr_data;
            end
            if (cmd.clr_en)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            walk_reg     <= walk_next;
            scan_idx_reg <= scan_idx_next;
            if (cmd.rpt_done)
            begin
                bits_reg <= '0;
                syms_reg <= '0;
            end
            else
            begin
                if (cmd.take_bit)
                begin
                    bits_reg <= bits_reg + 1'b1;
                end
                if (cmd.sym_done)
                begin
                    syms_reg <= syms_reg + 1'b1;
                end
            end
            if (cmd.mul)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Restoring divider, one quotient bit per cycle shifted into num_reg.
    assign den   = DEN_W'(syms_reg) << CHAR_SHIFT;
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    // Saturated efficiency, zero when no symbol was decoded.
    always_comb
    begin
        if (syms_reg == '0)
        begin
            eff = '0;
        end
        else if (num_reg[NUM_W-1:EFF_W] != '0)
        begin
            eff = '1;
        end
        else
        begin
            eff = num_reg[EFF_W-1:0];
        end
    end

    // Payload registers of the walk, scan and division.
    always_ff @(posedge clk)
    begin
        if (cmd.take_bit)
        begin
            bit_reg <= in_code_bit;
            eos_reg <= in_end_of_stream;
        end
        if (cmd.scan_start)
        begin
            found_reg <= 1'b0;
            char_reg  <= '0;
        end
        else if (cmd.scan_take)
        begin
            found_reg <= 1'b1;
            char_reg  <= map_char_rd_reg;
        end
        if (cmd.mul)
        begin
            num_reg <= NUM_W'(bits_reg) * NUM_W'(EFF_SCALE);
            rem_reg <= '0;
            inc_reg <= (walk_reg != TAW'(1));
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    // Result register; fields that a kind does not use are loaded as zero.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg <= cmd.out_kind;
            out_last_reg <= cmd.out_last;
            unique case (cmd.out_kind)
                KIND_SYMBOL:
                begin
                    out_weight_reg <= tree_rd_reg;
                    out_symbol_reg <= char_reg;
                    out_found_reg  <= found_reg;
                    out_eff_reg    <= '0;
                    out_inc_reg    <= 1'b0;
                end
                KIND_REPORT:
                begin
                    out_weight_reg <= '0;
                    out_symbol_reg <= '0;
                    out_found_reg  <= 1'b0;
                    out_eff_reg    <= eff;
                    out_inc_reg    <= inc_reg;
                end
                default:
                begin
                    out_weight_reg <= '0;
                    out_symbol_reg <= '0;
                    out_found_reg  <= 1'b0;
                    out_eff_reg    <= '0;
                    out_inc_reg    <= 1'b0;
                end
            endcase
        end
    end

    // Status back to the controller.
    always_comb
    begin
        status            = '0;
        status.clr_done   = (clr_idx_reg == TAW'(TREE_NODES - 1));
        status.has_left   = left_ok && (tree_rd_reg != '0);
        status.overflow   = 32'(child_pos) >= TREE_NODES;
        status.scan_empty = (slot_cnt == '0);
        status.scan_match = (32'(map_leaf_rd_reg) == 32'(walk_reg));
        status.scan_last  = (scan_idx_reg == '0);
        status.div_done   = (div_cnt_reg == DIVC_W'(NUM_W));
        status.eos        = eos_reg;
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid        = out_valid_reg;
    assign out_kind         = out_kind_reg;
    assign out_weight       = out_weight_reg;
    assign out_symbol       = out_symbol_reg;
    assign out_symbol_found = out_found_reg;
    assign out_efficiency   = out_eff_reg;
    assign out_incomplete   = out_inc_reg;
    assign out_last         = out_last_reg;

endmodule

### design/huffman_heap_tree_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_heap_tree_decoder
// Huffman decoder over a heap-ordered tree store with a symbol map lookup.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one command per beat, selected by s_axis_tuser:
// write a tree node, write a symbol map slot, or feed one code bit
// (s_axis_tlast marks the last bit of a stream). The master stream returns
// decoded symbols, tree overflow marks and, after the last bit, an
// efficiency report; m_axis_tlast flags the last result of one input beat.
// symbol_count is written through cfg_wr_en / cfg_wr_data while idle.
// Flow: a tree or map write is stored as its beat is taken. A code bit
// reads the tree through the single read port and, when it reaches a leaf,
// scans the map slots (up to SYMBOL_SLOTS) and then loads the result into
// the output register. A stream end adds the multiply and the 39-step
// bit-serial divider.
// Reset: the tree store is swept to zero, one node per cycle;
// s_axis_tready stays low until the sweep finishes.
// A single output register holds each result; when m_axis_tready is low the
// controller waits with the next result, while input is still taken once
// the current beat's work is done.
// ----------------------------------------------------------------------------
module huffman_heap_tree_decoder
#(
    parameter int TREE_NODES   = hhtd_pkg::TREE_NODES_DEF,
    parameter int SYMBOL_SLOTS = hhtd_pkg::SYMBOL_SLOTS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // address, node_weight, leaf_position, symbol_char, code_bit, zero pad
    input  logic [hhtd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic [hhtd_pkg::OP_W-1:0]       s_axis_tuser,
    input  logic                            s_axis_tlast,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // weight, symbol, symbol_found, efficiency_percent, incomplete, zero pad
    output logic [hhtd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // kind
    output logic [hhtd_pkg::KIND_W-1:0]     m_axis_tuser,
    output logic                            m_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            cfg_wr_en,
    input  logic [hhtd_pkg::SCNT_W-1:0]     cfg_wr_data
);
    import hhtd_pkg::*;

    cmd_t                cmd;
    status_t             status;
    kind_t               out_kind;
    logic [WEIGHT_W-1:0] out_weight;
    logic [CHAR_W-1:0]   out_symbol;
    logic                out_found;
    logic [EFF_W-1:0]    out_eff;
    logic                out_inc;

    // Controller.
    hhtd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (op_t'(s_axis_tuser)),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath, fed with the unpacked input beat.
    hhtd_datapath
    #(
        .TREE_NODES   (TREE_NODES),
        .SYMBOL_SLOTS (SYMBOL_SLOTS)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_address       (s_axis_tdata[9:0]),
        .in_node_weight   (s_axis_tdata[25:10]),
        .in_leaf_position (s_axis_tdata[35:26]),
        .in_symbol_char   (s_axis_tdata[43:36]),
        .in_code_bit      (s_axis_tdata[44]),
        .in_end_of_stream (s_axis_tlast),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .out_ready        (m_axis_tready),
        .out_valid        (m_axis_tvalid),
        .out_kind         (out_kind),
        .out_weight       (out_weight),
        .out_symbol       (out_symbol),
        .out_symbol_found (out_found),
        .out_efficiency   (out_eff),
        .out_incomplete   (out_inc),
        .out_last         (m_axis_tlast)
    );

    // Pack the result beat.
    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {6'd0, out_inc, out_eff, out_found, out_symbol, out_weight};

endmodule
